// File: rtl/core/cuil_pkg.sv
// ----------------------------------------------------------------------------
// cuil_pkg
// Shared types, character codes and small arithmetic helpers for the
// tax-code validator.
// ----------------------------------------------------------------------------
package cuil_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ID_W   = 27;
    localparam int unsigned POS_W  = 4;
    localparam int unsigned SUM_W  = 4;
    localparam int unsigned TYPE_W = 7;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned WGT_W  = 3;
    localparam int unsigned ACC_W  = 7;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_HYPHEN = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE   = 8'h39;

    // Buffer positions with a fixed meaning
    localparam logic [POS_W-1:0] POS_FIRST    = 4'd0;
    localparam logic [POS_W-1:0] POS_TYPE_END = 4'd2;
    localparam logic [POS_W-1:0] POS_HYPHEN_A = 4'd2;
    localparam logic [POS_W-1:0] POS_HYPHEN_B = 4'd11;
    localparam logic [POS_W-1:0] POS_CHECK    = 4'd12;
    localparam logic [POS_W-1:0] POS_END      = 4'd13;

    // Accepted two-digit types
    localparam logic [TYPE_W-1:0] TYPE_MALE    = 7'd20;
    localparam logic [TYPE_W-1:0] TYPE_FEMALE  = 7'd23;
    localparam logic [TYPE_W-1:0] TYPE_COMPANY = 7'd27;

    // Check digit mapping
    localparam logic [SUM_W-1:0] CHK_ELEVEN = 4'd11;
    localparam logic [SUM_W-1:0] CHK_TEN    = 4'd10;
    localparam logic [SUM_W-1:0] CHK_NINE   = 4'd9;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              start_req;
    } item_t;

    typedef struct packed {
        logic            valid_res;
        logic [ID_W-1:0] id_number;
    } result_t;

    // Weight of each body digit, by weight index
    function automatic logic [WGT_W-1:0] body_weight(input logic [POS_W-1:0] widx);
        logic [WGT_W-1:0] w;
        unique case (widx)
            4'd0:    w = 3'd5;
            4'd1:    w = 3'd4;
            4'd2:    w = 3'd3;
            4'd3:    w = 3'd2;
            4'd4:    w = 3'd7;
            4'd5:    w = 3'd6;
            4'd6:    w = 3'd5;
            4'd7:    w = 3'd4;
            4'd8:    w = 3'd3;
            4'd9:    w = 3'd2;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

    // Reduce a value below 77 modulo 11 by one selected subtraction
    function automatic logic [SUM_W-1:0] mod_eleven(input logic [ACC_W-1:0] v);
        logic [ACC_W-1:0] r;
        if (v >= 7'd66)
            r = v - 7'd66;
        else if (v >= 7'd55)
            r = v - 7'd55;
        else if (v >= 7'd44)
            r = v - 7'd44;
        else if (v >= 7'd33)
            r = v - 7'd33;
        else if (v >= 7'd22)
            r = v - 7'd22;
        else if (v >= 7'd11)
            r = v - 7'd11;
        else
            r = v;
        return r[SUM_W-1:0];
    endfunction

endpackage

// File: rtl/core/cuil_if.sv
// ----------------------------------------------------------------------------
// cuil_if
// Valid/ready channels carrying code bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface cuil_in_if;
    logic                          valid;
    logic                          ready;
    logic [cuil_pkg::CHAR_W-1:0]   char_code;
    logic                          start_req;

    modport source (output valid, output char_code, output start_req, input ready);
    modport sink   (input valid, input char_code, input start_req, output ready);
endinterface

interface cuil_out_if;
    logic                        valid;
    logic                        ready;
    logic                        valid_res;
    logic [cuil_pkg::ID_W-1:0]   id_number;

    modport source (output valid, output valid_res, output id_number, input ready);
    modport sink   (input valid, input valid_res, input id_number, output ready);
endinterface

// File: rtl/core/cuil_scan.sv
// ----------------------------------------------------------------------------
// cuil_scan
// Per-byte scanner: holds the buffer state and folds one registered byte
// into it per commit, producing the verdict on the terminator position.
// ----------------------------------------------------------------------------
module cuil_scan (
    input  logic              clk,
    input  logic              rst_n,
    input  cuil_pkg::item_t   item,
    input  logic              commit,
    output logic              emit,
    output cuil_pkg::result_t result
);

    logic [cuil_pkg::POS_W-1:0]  position_reg,  position_next;
    logic                        error_reg,     error_next;
    logic [cuil_pkg::SUM_W-1:0]  sum_reg,       sum_next;
    logic [cuil_pkg::TYPE_W-1:0] type_reg,      type_next;
    logic [cuil_pkg::ID_W-1:0]   id_reg,        id_next;
    logic [cuil_pkg::DIG_W-1:0]  check_reg,     check_next;

    logic                        active;
    logic [cuil_pkg::POS_W-1:0]  eff_pos;
    logic                        eff_err;
    logic [cuil_pkg::SUM_W-1:0]  eff_sum;
    logic [cuil_pkg::TYPE_W-1:0] eff_type;
    logic [cuil_pkg::ID_W-1:0]   eff_id;
    logic [cuil_pkg::DIG_W-1:0]  eff_check;
    logic                        is_digit;
    logic [cuil_pkg::CHAR_W-1:0] digit_diff;
    logic [cuil_pkg::DIG_W-1:0]  digit_val;
    logic [cuil_pkg::POS_W-1:0]  widx;
    logic [cuil_pkg::ACC_W-1:0]  product;
    logic [cuil_pkg::ACC_W-1:0]  sum_wide;
    logic [cuil_pkg::TYPE_W+3:0] type_wide;
    logic [cuil_pkg::ID_W+3:0]   id_wide;
    logic [cuil_pkg::SUM_W-1:0]  expect_raw;
    logic [cuil_pkg::SUM_W-1:0]  expect_digit;
    logic                        type_ok;
    logic                        ok;

    // Start a fresh buffer on start_req, otherwise continue the current one
    always_comb
    begin
        active    = item.start_req || (position_reg != cuil_pkg::POS_FIRST);
        eff_pos   = item.start_req ? cuil_pkg::POS_FIRST : position_reg;
        eff_err   = item.start_req ? 1'b0 : error_reg;
        eff_sum   = item.start_req ? '0 : sum_reg;
        eff_type  = item.start_req ? '0 : type_reg;
        eff_id    = item.start_req ? '0 : id_reg;
        eff_check = item.start_req ? '0 : check_reg;
    end

    // Decode the byte and form the digit arithmetic
    always_comb
    begin
        is_digit   = (item.char_code >= cuil_pkg::CHAR_ZERO) &&
                     (item.char_code <= cuil_pkg::CHAR_NINE);
        digit_diff = item.char_code - cuil_pkg::CHAR_ZERO;
        digit_val  = digit_diff[cuil_pkg::DIG_W-1:0];
        widx       = (eff_pos < cuil_pkg::POS_TYPE_END) ? eff_pos : (eff_pos - 4'd1);
        product    = {3'b000, digit_val} * {4'b0000, cuil_pkg::body_weight(widx)};
        sum_wide   = {3'b000, eff_sum} + product;
        type_wide  = ({4'b0000, eff_type} << 3) + ({4'b0000, eff_type} << 1)
                     + {7'd0, digit_val};
        id_wide    = ({4'b0000, eff_id} << 3) + ({4'b0000, eff_id} << 1)
                     + {27'd0, digit_val};
    end

    // Expected check digit and verdict
    always_comb
    begin
        expect_raw = cuil_pkg::CHK_ELEVEN - eff_sum;
        if (expect_raw == cuil_pkg::CHK_ELEVEN)
            expect_digit = '0;
        else if (expect_raw == cuil_pkg::CHK_TEN)
            expect_digit = cuil_pkg::CHK_NINE;
        else
            expect_digit = expect_raw;
        type_ok = (eff_type == cuil_pkg::TYPE_MALE) ||
                  (eff_type == cuil_pkg::TYPE_FEMALE) ||
                  (eff_type == cuil_pkg::TYPE_COMPANY);
        ok = !eff_err && (item.char_code == cuil_pkg::CHAR_NUL) && type_ok &&
             (eff_check == expect_digit);
        result.valid_res = ok;
        result.id_number = ok ? eff_id : '0;
    end

    // Advance the buffer state by one byte
    always_comb
    begin
        position_next = eff_pos + 4'd1;
        error_next    = eff_err;
        sum_next      = eff_sum;
        type_next     = eff_type;
        id_next       = eff_id;
        check_next    = eff_check;
        emit          = 1'b0;
        if (!active)
        begin
            position_next = position_reg;
            error_next    = error_reg;
            sum_next      = sum_reg;
            type_next     = type_reg;
            id_next       = id_reg;
            check_next    = check_reg;
        end
        else if ((eff_pos == cuil_pkg::POS_HYPHEN_A) || (eff_pos == cuil_pkg::POS_HYPHEN_B))
        begin
            if (item.char_code != cuil_pkg::CHAR_HYPHEN)
                error_next = 1'b1;
        end
        else if (eff_pos == cuil_pkg::POS_END)
        begin
            emit          = 1'b1;
            position_next = cuil_pkg::POS_FIRST;
        end
        else if (!is_digit)
        begin
            error_next = 1'b1;
        end
        else if (eff_pos == cuil_pkg::POS_CHECK)
        begin
            check_next = digit_val;
        end
        else
        begin
            sum_next = cuil_pkg::mod_eleven(sum_wide);
            if (eff_pos < cuil_pkg::POS_TYPE_END)
                type_next = type_wide[cuil_pkg::TYPE_W-1:0];
            else
                id_next = id_wide[cuil_pkg::ID_W-1:0];
        end
    end

    // Commit the state when the byte leaves the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            error_reg    <= 1'b0;
            sum_reg      <= '0;
            type_reg     <= '0;
            id_reg       <= '0;
            check_reg    <= '0;
        end
        else if (commit)
        begin
            position_reg <= position_next;
            error_reg    <= error_next;
            sum_reg      <= sum_next;
            type_reg     <= type_next;
            id_reg       <= id_next;
            check_reg    <= check_next;
        end
    end

endmodule

// File: rtl/core/cuil_code_validator_unit.sv
// ----------------------------------------------------------------------------
// cuil_code_validator_unit
// Tax-code validator: one code byte per item, one verdict per buffer.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, except that a terminator byte waits while the result register is full and not taken.
// A verdict is offered once its terminator byte has passed through the input
// register and its result has been loaded into the result register.
// Reset: asynchronous, active low; clears the buffer state to idle and
// empties both registers.
module cuil_code_validator_unit (
    input  logic            clk,
    input  logic            rst_n,
    cuil_in_if.sink         char_stream,
    cuil_out_if.source      verdict
);

    logic              in_valid_reg;
    cuil_pkg::item_t   in_item_reg;
    logic              out_valid_reg;
    cuil_pkg::result_t out_data_reg;

    logic              emit;
    logic              out_free;
    logic              advance;
    cuil_pkg::result_t result;

    // Move the held byte on unless its verdict has no room
    assign out_free          = !out_valid_reg || verdict.ready;
    assign advance           = in_valid_reg && (!emit || out_free);
    assign char_stream.ready = !in_valid_reg || advance;

    cuil_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (in_item_reg),
        .commit (advance),
        .emit   (emit),
        .result (result)
    );

    // Input register: take an item when empty or whenever the held one moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (char_stream.valid && char_stream.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (char_stream.valid && char_stream.ready)
        begin
            in_item_reg.char_code <= char_stream.char_code;
            in_item_reg.start_req <= char_stream.start_req;
        end
    end

    // Result register: load a verdict, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (verdict.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
            out_data_reg <= result;
    end

    assign verdict.valid     = out_valid_reg;
    assign verdict.valid_res = out_data_reg.valid_res;
    assign verdict.id_number = out_data_reg.id_number;

endmodule
